// File: hw/rtl/lqp_pkg.sv
// ----------------------------------------------------------------------------
// Locality-aware queue placement package
// Shared widths, codes, channel payloads and the control/status bundles.
// ----------------------------------------------------------------------------
package lqp_pkg;

	localparam int MAX_SLOTS  = 32;
	localparam int SLOT_W     = $clog2(MAX_SLOTS);
	localparam int TOT_W      = SLOT_W + 1;
	localparam int CNT_W      = 11;
	localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};
	localparam int TXN_W      = 10;
	localparam int ID_W       = 32;
	localparam int DIV_CNT_W  = $clog2(ID_W);
	localparam int NODE_W     = 3;
	localparam int NN_W       = 4;
	localparam int EXTRA_W    = 5;
	localparam int KIND_W     = 2;
	localparam int CFG_DATA_W = 5;

	localparam logic MODE_PLACE = 1'b0;
	localparam logic MODE_BATCH = 1'b1;

	localparam logic [KIND_W-1:0] KIND_SPRAY = 2'd0;
	localparam logic [KIND_W-1:0] KIND_BOTH  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_FIRST = 2'd2;

	localparam logic [NN_W-1:0]    NUM_NODES_RST   = 4'd2;
	localparam logic [NODE_W-1:0]  LOCAL_NODE_RST  = 3'd0;
	localparam logic [EXTRA_W-1:0] EXTRA_LOCAL_RST = 5'd0;
	localparam logic               SCHED_EN_RST    = 1'b1;

	typedef enum logic [1:0] {
		CFG_NUM_NODES   = 2'd0,
		CFG_LOCAL_NODE  = 2'd1,
		CFG_EXTRA_LOCAL = 2'd2,
		CFG_SCHED_EN    = 2'd3
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_SCAN,
		ST_SETTLE,
		ST_PICK,
		ST_READ,
		ST_COMMIT
	} state_t;

	typedef struct packed {
		logic              mode;
		logic [TXN_W-1:0]  txn_index;
		logic              has_first;
		logic [NODE_W-1:0] first_target;
		logic [ID_W-1:0]   first_id;
		logic              has_second;
		logic [NODE_W-1:0] second_target;
		logic [ID_W-1:0]   second_id;
	} txn_t;

	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic [TXN_W-1:0]  placed_txn;
		logic [KIND_W-1:0] placement_kind;
	} result_t;

	typedef struct packed {
		logic load;
		logic clear;
		logic div_step;
		logic scan_step;
		logic pick;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic in_mode;
		logic in_sched;
		logic div_last;
		logic scan_last;
		logic out_busy;
	} stat_t;

endpackage

// File: hw/rtl/lqp_if.sv
// ----------------------------------------------------------------------------
// Locality-aware queue placement channel interfaces
// Transaction input, placement output and register write channels.
// ----------------------------------------------------------------------------
interface lqp_txn_if;
	logic                         valid;
	logic                         ready;
	logic                         mode;
	logic [lqp_pkg::TXN_W-1:0]    txn_index;
	logic                         has_first;
	logic [lqp_pkg::NODE_W-1:0]   first_target;
	logic [lqp_pkg::ID_W-1:0]     first_id;
	logic                         has_second;
	logic [lqp_pkg::NODE_W-1:0]   second_target;
	logic [lqp_pkg::ID_W-1:0]     second_id;

	modport source (
		output valid, mode, txn_index, has_first, first_target, first_id,
		       has_second, second_target, second_id,
		input  ready
	);
	modport sink (
		input  valid, mode, txn_index, has_first, first_target, first_id,
		       has_second, second_target, second_id,
		output ready
	);
endinterface

interface lqp_place_if;
	logic                         valid;
	logic                         ready;
	logic [lqp_pkg::SLOT_W-1:0]   slot;
	logic [lqp_pkg::TXN_W-1:0]    placed_txn;
	logic [lqp_pkg::KIND_W-1:0]   placement_kind;

	modport source (output valid, slot, placed_txn, placement_kind, input ready);
	modport sink (input valid, slot, placed_txn, placement_kind, output ready);
endinterface

interface lqp_cfg_if;
	logic                             valid;
	logic                             ready;
	lqp_pkg::cfg_reg_t                index;
	logic [lqp_pkg::CFG_DATA_W-1:0]   data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: hw/rtl/locality_aware_queue_placement_core.sv
// ----------------------------------------------------------------------------
// Locality-aware queue placement core
// Assigns each transaction to a mini-batch queue using the locality schedule.
// ----------------------------------------------------------------------------
// The txn channel takes one item per transfer. A batch-start item clears all
// per-slot counts and the round-robin index and gives no result.
// A placement item gives exactly one transfer on the placement channel.
// With the schedule enabled and a first hot operation present, an item runs a
// bit-serial remainder for both schedule rows, a scan of the count of every
// active slot (at most 32) through the memory read port, then pick, read and
// update of the chosen count. A sprayed item goes straight to the pick, read
// and update of the round-robin slot's count.
// One item is in work at a time; the next transfer is taken once the result
// is in the output register, while that result may still be waiting.
// The cfg channel is always ready and must be written only while idle.
// Reset restores the register defaults and marks every count as zero; no
// clearing pass is needed. When the receiver stalls, the result holds in the
// output register and the next item waits before its count update.
// ----------------------------------------------------------------------------
module locality_aware_queue_placement_core (
	input  logic        clk,
	input  logic        arst_n,
	lqp_txn_if.sink     txn,
	lqp_place_if.source placement,
	lqp_cfg_if.sink     cfg
);
	import lqp_pkg::*;

	cmd_t    cmd;
	stat_t   stat;
	txn_t    txn_data;
	result_t out_data;
	logic    in_ready;
	logic    out_valid;

	assign txn_data.mode          = txn.mode;
	assign txn_data.txn_index     = txn.txn_index;
	assign txn_data.has_first     = txn.has_first;
	assign txn_data.first_target  = txn.first_target;
	assign txn_data.first_id      = txn.first_id;
	assign txn_data.has_second    = txn.has_second;
	assign txn_data.second_target = txn.second_target;
	assign txn_data.second_id     = txn.second_id;

	assign txn.ready = in_ready;
	assign cfg.ready = 1'b1;

	assign placement.valid          = out_valid;
	assign placement.slot           = out_data.slot;
	assign placement.placed_txn     = out_data.placed_txn;
	assign placement.placement_kind = out_data.placement_kind;

	lqp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (txn.valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	lqp_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.txn_data  (txn_data),
		.cfg_we    (cfg.valid),
		.cfg_idx   (cfg.index),
		.cfg_data  (cfg.data),
		.out_ready (placement.ready),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

endmodule

// File: hw/rtl/lqp_ctrl.sv
// ----------------------------------------------------------------------------
// Locality-aware queue placement controller
// Sequences the row division, the slot scan, the pick and the count update.
// ----------------------------------------------------------------------------
module lqp_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  lqp_pkg::stat_t stat,
	output lqp_pkg::cmd_t  cmd
);
	import lqp_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		accept   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				accept   = in_valid;
				if (accept) begin
					if (stat.in_mode == MODE_BATCH) begin
						cmd.clear = 1'b1;
					end else begin
						cmd.load = 1'b1;
						state_d  = stat.in_sched ? ST_DIV : ST_PICK;
					end
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (stat.scan_last) begin
					state_d = ST_SETTLE;
				end
			end
			ST_SETTLE: begin
				state_d = ST_PICK;
			end
			ST_PICK: begin
				cmd.pick = 1'b1;
				state_d  = ST_READ;
			end
			ST_READ: begin
				state_d = ST_COMMIT;
			end
			ST_COMMIT: begin
				if (!stat.out_busy) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// File: hw/rtl/lqp_dp.sv
// ----------------------------------------------------------------------------
// Locality-aware queue placement datapath
// Configuration, row remainders, slot count memory, scan and output register.
// ----------------------------------------------------------------------------
module lqp_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  lqp_pkg::cmd_t                  cmd,
	output lqp_pkg::stat_t                 stat,
	input  lqp_pkg::txn_t                  txn_data,
	input  logic                           cfg_we,
	input  lqp_pkg::cfg_reg_t              cfg_idx,
	input  logic [lqp_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           out_ready,
	output logic                           out_valid,
	output lqp_pkg::result_t               out_data
);
	import lqp_pkg::*;

	logic [NN_W-1:0]      num_nodes_q;
	logic [NODE_W-1:0]    local_node_q;
	logic [EXTRA_W-1:0]   extra_local_q;
	logic                 sched_en_q;

	logic [TXN_W-1:0]     txn_idx_q;
	logic                 has_second_q;
	logic [NODE_W-1:0]    tgt_a_q;
	logic [NODE_W-1:0]    tgt_b_q;
	logic [ID_W-1:0]      div_a_q;
	logic [ID_W-1:0]      div_b_q;
	logic [SLOT_W-1:0]    rem_a_q;
	logic [SLOT_W-1:0]    rem_b_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic [SLOT_W-1:0]    scan_idx_q;

	logic                 vld_s1;
	logic [SLOT_W-1:0]    idx_s1;
	logic                 ea_s1;
	logic                 eb_s1;

	logic [CNT_W-1:0]     cnt_mem [MAX_SLOTS];
	logic [MAX_SLOTS-1:0] cnt_vld_q;
	logic [CNT_W-1:0]     rdata_s1;
	logic                 rvalid_s1;

	logic                 fb_q;
	logic [SLOT_W-1:0]    bb_idx_q;
	logic [CNT_W-1:0]     bb_cnt_q;
	logic                 ff_q;
	logic [SLOT_W-1:0]    bf_idx_q;
	logic [CNT_W-1:0]     bf_cnt_q;

	logic [SLOT_W-1:0]    spray_q;
	logic [SLOT_W-1:0]    chosen_q;
	logic [KIND_W-1:0]    kind_q;
	logic                 out_vld_q;
	result_t              out_q;

	logic [TOT_W-1:0]     divisor;
	logic [TOT_W-1:0]     sum_slots;
	logic [TOT_W-1:0]     total;
	logic [TOT_W-1:0]     t_a;
	logic [TOT_W-1:0]     t_b;
	logic [SLOT_W-1:0]    rem_a_d;
	logic [SLOT_W-1:0]    rem_b_d;
	logic [SLOT_W-1:0]    rd_addr;
	logic [CNT_W-1:0]     cnt_eff;
	logic [CNT_W-1:0]     cnt_new;
	logic [SLOT_W-1:0]    spray_pick;
	logic [TOT_W-1:0]     spray_inc;
	logic                 elig_a;
	logic                 elig_b;

	function automatic logic slot_elig(
		input logic [SLOT_W-1:0] s,
		input logic [SLOT_W-1:0] r,
		input logic [NODE_W-1:0] tgt,
		input logic [NN_W-1:0]   nodes,
		input logic [NODE_W-1:0] here
	);
		logic [TOT_W-1:0]  hi;
		logic [SLOT_W-1:0] diff;
		logic              inrow;
		hi    = {1'b0, r} + TOT_W'(nodes);
		inrow = (s >= r) && ({1'b0, s} < hi);
		diff  = s - r;
		return inrow ? (diff == SLOT_W'(here)) : (tgt == here);
	endfunction

	assign divisor   = TOT_W'(extra_local_q) + TOT_W'(1);
	assign sum_slots = TOT_W'(extra_local_q) + TOT_W'(num_nodes_q);
	always_comb begin
		if (sum_slots > TOT_W'(MAX_SLOTS)) begin
			total = TOT_W'(MAX_SLOTS);
		end else if (sum_slots == '0) begin
			total = TOT_W'(1);
		end else begin
			total = sum_slots;
		end
	end

	assign t_a     = {rem_a_q, div_a_q[ID_W-1]};
	assign t_b     = {rem_b_q, div_b_q[ID_W-1]};
	assign rem_a_d = (t_a >= divisor) ? SLOT_W'(t_a - divisor) : SLOT_W'(t_a);
	assign rem_b_d = (t_b >= divisor) ? SLOT_W'(t_b - divisor) : SLOT_W'(t_b);

	assign elig_a = slot_elig(scan_idx_q, rem_a_q, tgt_a_q, num_nodes_q, local_node_q);
	assign elig_b = slot_elig(scan_idx_q, rem_b_q, tgt_b_q, num_nodes_q, local_node_q);

	assign rd_addr = cmd.scan_step ? scan_idx_q : chosen_q;
	assign cnt_eff = rvalid_s1 ? rdata_s1 : '0;
	assign cnt_new = (cnt_eff == COUNT_MAX) ? cnt_eff : cnt_eff + CNT_W'(1);

	assign spray_pick = ({1'b0, spray_q} < total) ? spray_q : '0;
	assign spray_inc  = {1'b0, spray_pick} + TOT_W'(1);

	assign stat.in_mode   = txn_data.mode;
	assign stat.in_sched  = sched_en_q & txn_data.has_first;
	assign stat.div_last  = (div_cnt_q == DIV_CNT_W'(ID_W - 1));
	assign stat.scan_last = ({1'b0, scan_idx_q} == (total - TOT_W'(1)));
	assign stat.out_busy  = out_vld_q & ~out_ready;

	assign out_valid = out_vld_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_nodes_q   <= NUM_NODES_RST;
			local_node_q  <= LOCAL_NODE_RST;
			extra_local_q <= EXTRA_LOCAL_RST;
			sched_en_q    <= SCHED_EN_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_NUM_NODES:   num_nodes_q   <= cfg_data[NN_W-1:0];
				CFG_LOCAL_NODE:  local_node_q  <= cfg_data[NODE_W-1:0];
				CFG_EXTRA_LOCAL: extra_local_q <= cfg_data[EXTRA_W-1:0];
				CFG_SCHED_EN:    sched_en_q    <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			txn_idx_q    <= txn_data.txn_index;
			has_second_q <= txn_data.has_second;
			tgt_a_q      <= txn_data.first_target;
			tgt_b_q      <= txn_data.second_target;
			div_a_q      <= txn_data.first_id;
			div_b_q      <= txn_data.second_id;
			rem_a_q      <= '0;
			rem_b_q      <= '0;
			div_cnt_q    <= '0;
			scan_idx_q   <= '0;
		end else if (cmd.div_step) begin
			div_a_q   <= {div_a_q[ID_W-2:0], 1'b0};
			div_b_q   <= {div_b_q[ID_W-2:0], 1'b0};
			rem_a_q   <= rem_a_d;
			rem_b_q   <= rem_b_d;
			div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
		end else if (cmd.scan_step) begin
			scan_idx_q <= scan_idx_q + SLOT_W'(1);
		end
		idx_s1 <= scan_idx_q;
		ea_s1  <= elig_a;
		eb_s1  <= elig_a & elig_b & has_second_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			cnt_mem[chosen_q] <= cnt_new;
		end
		rdata_s1 <= cnt_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_vld_q <= '0;
			rvalid_s1 <= 1'b0;
			vld_s1    <= 1'b0;
			spray_q   <= '0;
			fb_q      <= 1'b0;
			ff_q      <= 1'b0;
		end else begin
			rvalid_s1 <= cnt_vld_q[rd_addr];
			vld_s1    <= cmd.scan_step;
			if (cmd.clear) begin
				cnt_vld_q <= '0;
				spray_q   <= '0;
			end else if (cmd.commit) begin
				cnt_vld_q[chosen_q] <= 1'b1;
			end
			if (cmd.pick && !fb_q && !ff_q) begin
				spray_q <= (spray_inc >= total) ? '0 : SLOT_W'(spray_inc);
			end
			if (cmd.load) begin
				fb_q <= 1'b0;
				ff_q <= 1'b0;
			end else if (vld_s1) begin
				if (eb_s1 && (!fb_q || cnt_eff < bb_cnt_q)) begin
					fb_q <= 1'b1;
				end
				if (ea_s1 && (!ff_q || cnt_eff < bf_cnt_q)) begin
					ff_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			if (eb_s1 && (!fb_q || cnt_eff < bb_cnt_q)) begin
				bb_idx_q <= idx_s1;
				bb_cnt_q <= cnt_eff;
			end
			if (ea_s1 && (!ff_q || cnt_eff < bf_cnt_q)) begin
				bf_idx_q <= idx_s1;
				bf_cnt_q <= cnt_eff;
			end
		end
		if (cmd.pick) begin
			if (fb_q) begin
				chosen_q <= bb_idx_q;
				kind_q   <= KIND_BOTH;
			end else if (ff_q) begin
				chosen_q <= bf_idx_q;
				kind_q   <= KIND_FIRST;
			end else begin
				chosen_q <= spray_pick;
				kind_q   <= KIND_SPRAY;
			end
		end
		if (cmd.commit) begin
			out_q.slot           <= chosen_q;
			out_q.placed_txn     <= txn_idx_q;
			out_q.placement_kind <= kind_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.commit) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> ({1'b0, rem_a_q} < divisor) && ({1'b0, rem_b_q} < divisor))
		else $error("row remainder reached the divisor");

	a_chosen_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> ({1'b0, chosen_q} < total))
		else $error("chosen slot lies beyond the active slot count");

	a_no_result_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!out_vld_q || out_ready))
		else $error("new placement written over an untaken result");

	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> (out_q.placement_kind == KIND_SPRAY ||
			out_q.placement_kind == KIND_BOTH || out_q.placement_kind == KIND_FIRST))
		else $error("placement kind code out of range");

endmodule
